@@ design/rmsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmsl_pkg;

  // Default list depth
  localparam int unsigned ListDepthDef = 64;

  // Fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned TsW     = 31;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CntOutW = 7;

  // Stream widths (fields padded to whole bytes)
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_QUERY  = 3'd0,
    CMD_MARK   = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_READ   = 3'd4,
    CMD_SAVED  = 3'd5,
    CMD_EMPTY  = 3'd6
  } cmd_e;

  // One result item, unread in bit 0
  typedef struct packed {
    logic               status;
    logic               dirty;
    logic [CntOutW-1:0] entry_count;
    logic [TsW-1:0]     entry_value;
    logic               unread;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

@@ design/read_mark_sorted_list_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Fields (lsb first)
// ----------+-----+---------------------------------------------------------
// s_axis    | in  | tdata: timestamp[30:0], entry_index[36:31], zero pad
//           |     | tuser: command[2:0]
// m_axis    | out | tdata: unread[0], entry_value[31:1], entry_count[38:32],
//           |     |        dirty[39], status[40], zero pad
//
// One item at a time. Query and mark compare entries one by one on the cursor
// walk (up to LIST_DEPTH entries); a mark that inserts also shifts entries
// (up to LIST_DEPTH - 1), all through the single read port of the memory.
// Reset clears count, cursor, dirty flag and control, not the entry memory.
// A result stalled in the output register holds the next item at its response step.

module read_mark_sorted_list_unit #(
  parameter int unsigned LIST_DEPTH = rmsl_pkg::ListDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // timestamp, entry_index, pad
  input  wire logic [rmsl_pkg::InDataW-1:0]  s_axis_tdata,
  // command
  input  wire logic [rmsl_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // unread, entry_value, entry_count, dirty, status, pad
  output logic [rmsl_pkg::OutDataW-1:0]      m_axis_tdata
);

  import rmsl_pkg::*;

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW    = $clog2(LIST_DEPTH);
  localparam int unsigned CMP_W = ((CNT_W > IdxW) ? CNT_W : IdxW) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PROBE,
    S_FWD,
    S_BWD,
    S_GROW,
    S_SHRD,
    S_SHWR,
    S_INS,
    S_RDOUT,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [TsW-1:0]     ts_q, ts_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   cursor_q, cursor_d;
  logic [CNT_W-1:0]   sh_q, sh_d;
  logic               changed_q, changed_d;
  logic               unread_q, unread_d;
  logic [TsW-1:0]     value_q, value_d;
  logic               status_q, status_d;
  logic               m_valid_q, m_valid_d;
  result_t            m_res_q, m_res_d;

  // Entry memory ports
  logic [TsW-1:0]     mem [LIST_DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [TsW-1:0]     mem_wd;
  logic [AW-1:0]      mem_ra;
  logic [TsW-1:0]     rd_data_q;

  // Datapath helpers
  logic [CNT_W-1:0]   cur_inc, cur_dec, cur_dec2, cur_clamp;
  logic [CNT_W-1:0]   sh_dec, sh_dec2;
  logic               ts_eq, ts_gt, ts_lt;
  logic               has_room, idx_ok;
  logic               walk_done, walk_unread;

  assign cur_inc   = cursor_q + CNT_W'(1);
  assign cur_dec   = cursor_q - CNT_W'(1);
  assign cur_dec2  = cursor_q - CNT_W'(2);
  assign cur_clamp = (cursor_q >= count_q) ? (count_q - CNT_W'(1)) : cursor_q;
  assign sh_dec    = sh_q - CNT_W'(1);
  assign sh_dec2   = sh_q - CNT_W'(2);

  assign ts_eq = (ts_q == rd_data_q);
  assign ts_gt = (ts_q >  rd_data_q);
  assign ts_lt = (ts_q <  rd_data_q);

  assign has_room = (count_q < CNT_W'(LIST_DEPTH));
  assign idx_ok   = (CMP_W'(idx_q) < CMP_W'(count_q)) &&
                    (CMP_W'(idx_q) < CMP_W'(LIST_DEPTH));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OutDataW - ResultW)'(0), m_res_q};

  // Next-state and memory access logic
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ts_d        = ts_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    sh_d        = sh_q;
    changed_d   = changed_q;
    unread_d    = unread_q;
    value_d     = value_q;
    status_d    = status_q;
    m_valid_d   = m_valid_q;
    m_res_d     = m_res_q;
    mem_we      = 1'b0;
    mem_wa      = cursor_q[AW-1:0];
    mem_wd      = ts_q;
    mem_ra      = cursor_q[AW-1:0];
    walk_done   = 1'b0;
    walk_unread = 1'b0;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          ts_d    = s_axis_tdata[TsW-1:0];
          idx_d   = s_axis_tdata[TsW+IdxW-1:TsW];
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unread_d = 1'b0;
        value_d  = '0;
        status_d = 1'b0;
        state_d  = S_RESP;
        case (cmd_q)
          CMD_QUERY, CMD_MARK: begin
            if (count_q == '0) begin
              cursor_d    = '0;
              walk_done   = 1'b1;
              walk_unread = 1'b1;
            end else begin
              cursor_d = cur_clamp;
              mem_ra   = cur_clamp[AW-1:0];
              state_d  = S_PROBE;
            end
          end
          CMD_CLEAR: begin
            mem_we    = 1'b1;
            mem_wa    = '0;
            count_d   = CNT_W'(1);
            cursor_d  = '0;
            changed_d = 1'b1;
          end
          CMD_APPEND: begin
            if (has_room) begin
              mem_we  = 1'b1;
              mem_wa  = count_q[AW-1:0];
              count_d = count_q + CNT_W'(1);
            end else begin
              status_d = 1'b1;
            end
          end
          CMD_READ: begin
            if (idx_ok) begin
              mem_ra  = AW'(idx_q);
              state_d = S_RDOUT;
            end else begin
              status_d = 1'b1;
            end
          end
          CMD_SAVED: begin
            changed_d = 1'b0;
          end
          CMD_EMPTY: begin
            count_d   = '0;
            cursor_d  = '0;
            changed_d = 1'b0;
          end
          default: ;
        endcase
      end

      // rd_data_q holds the entry at the cursor
      S_PROBE, S_FWD: begin
        if (ts_gt && (state_q == S_PROBE)) begin
          if (cursor_q == '0) begin
            walk_done   = 1'b1;
            walk_unread = 1'b1;
          end else begin
            mem_ra  = cur_dec[AW-1:0];
            state_d = S_BWD;
          end
        end else if (ts_eq) begin
          walk_done = 1'b1;
        end else if (ts_gt) begin
          walk_done   = 1'b1;
          walk_unread = 1'b1;
        end else begin
          cursor_d = cur_inc;
          if (cur_inc == count_q) begin
            // below the oldest entry
            walk_done = 1'b1;
          end else begin
            mem_ra  = cur_inc[AW-1:0];
            state_d = S_FWD;
          end
        end
      end

      // rd_data_q holds the entry just above the cursor
      S_BWD: begin
        if (ts_lt) begin
          walk_done   = 1'b1;
          walk_unread = 1'b1;
        end else begin
          cursor_d = cur_dec;
          if (ts_eq) begin
            walk_done = 1'b1;
          end else if (cur_dec == '0) begin
            walk_done   = 1'b1;
            walk_unread = 1'b1;
          end else begin
            mem_ra = cur_dec2[AW-1:0];
          end
        end
      end

      // Grow the list, oldest entry falls off when full
      S_GROW: begin
        if (has_room) begin
          count_d = count_q + CNT_W'(1);
          sh_d    = count_q;
        end else begin
          sh_d = count_q - CNT_W'(1);
        end
        state_d = S_SHRD;
      end

      S_SHRD: begin
        if (sh_q == cursor_q) begin
          state_d = S_INS;
        end else begin
          mem_ra  = sh_dec[AW-1:0];
          state_d = S_SHWR;
        end
      end

      // Move one entry down per cycle, read two slots ahead
      S_SHWR: begin
        mem_we = 1'b1;
        mem_wa = sh_q[AW-1:0];
        mem_wd = rd_data_q;
        sh_d   = sh_dec;
        if (sh_dec == cursor_q) begin
          state_d = S_INS;
        end else begin
          mem_ra = sh_dec2[AW-1:0];
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_wa    = cursor_q[AW-1:0];
        changed_d = 1'b1;
        state_d   = S_RESP;
      end

      S_RDOUT: begin
        value_d = rd_data_q;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d               = 1'b1;
          m_res_d.unread          = unread_q;
          m_res_d.entry_value     = value_q;
          m_res_d.entry_count     = CntOutW'(count_q);
          m_res_d.dirty           = changed_q;
          m_res_d.status          = status_q;
          state_d                 = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // End of cursor walk
    if (walk_done) begin
      unread_d = walk_unread;
      state_d  = ((cmd_q == CMD_MARK) && walk_unread) ? S_GROW : S_RESP;
    end
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      changed_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      changed_q <= changed_d;
      m_valid_q <= m_valid_d;
      cmd_q     <= cmd_d;
      ts_q      <= ts_d;
      idx_q     <= idx_d;
      sh_q      <= sh_d;
      unread_q  <= unread_d;
      value_q   <= value_d;
      status_q  <= status_d;
      m_res_q   <= m_res_d;
    end
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond entry count");

  a_shift_above_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHWR) |-> (sh_q > cursor_q))
    else $error("shift write at or above insert point");

  a_insert_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (cursor_q < count_q))
    else $error("insert outside held entries");

  a_walk_needs_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_FWD || state_q == S_BWD) |-> (count_q != '0))
    else $error("cursor walk on empty list");

endmodule

`default_nettype wire
